@@ sv/rrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrp_pkg: shared types and constants of the RESP request parser
// Byte codes, phase and error encodings, register indexes and result layout.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int unsigned NumWidthDefault = 32;

  localparam int unsigned ArgsWidth  = 16;
  localparam int unsigned BulkWidth  = 30;
  localparam int unsigned CfgWidth   = 30;

  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  localparam logic [ArgsWidth-1:0] MaxArgsReset    = 16'd1024;
  localparam logic [BulkWidth-1:0] MaxBulkLenReset = 30'd536870912;

  typedef enum logic {
    REG_MAX_ARGS     = 1'b0,
    REG_MAX_BULK_LEN = 1'b1
  } reg_index_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ARR_NUM = 3'd1,
    PH_LEN_NUM = 3'd2,
    PH_ARR_LF  = 3'd3,
    PH_LEN_LF  = 3'd4,
    PH_DATA1   = 3'd5,
    PH_DATA    = 3'd6,
    PH_ERR     = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NESTED     = 3'd1,
    ERR_NO_ARRAY   = 3'd2,
    ERR_UNEXPECTED = 3'd3,
    ERR_BAD_NUMBER = 3'd4
  } err_code_e;

  // Parser state apart from the number accumulator, whose width is a parameter.
  typedef struct packed {
    phase_e                phase;
    logic [ArgsWidth-1:0]  args_expected;
    logic [ArgsWidth-1:0]  args_seen;
    logic [BulkWidth-1:0]  bulk_remaining;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic [ArgsWidth-1:0]  arg_index;
    logic                  first_of_arg;
    logic                  last_of_arg;
    logic                  last_of_command;
    logic                  is_error;
    err_code_e             error_code;
  } result_t;

endpackage

@@ sv/rrp_step.sv @@
// ----------------------------------------------------------------------------
// rrp_step: next-state and result logic for one request byte
// Decodes headers, accumulates numbers, checks limits and tags payload bytes.
// ----------------------------------------------------------------------------
module rrp_step import rrp_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NumWidthDefault
) (
  input  parse_state_t           state_i,
  input  logic [NUM_WIDTH-1:0]   acc_i,
  input  logic [7:0]             byte_i,
  input  logic [ArgsWidth-1:0]   max_args_i,
  input  logic [BulkWidth-1:0]   max_bulk_len_i,
  output parse_state_t           state_o,
  output logic [NUM_WIDTH-1:0]   acc_o,
  output logic                   emit_o,
  output result_t                result_o
);

  localparam int unsigned CmpWidth = (NUM_WIDTH > BulkWidth) ? NUM_WIDTH : BulkWidth;
  localparam logic [NUM_WIDTH-1:0] SatValue = '1;

  logic                   is_cr;
  logic                   is_lf;
  logic                   is_digit;
  logic [7:0]             digit_full;
  logic [NUM_WIDTH+3:0]   acc_wide;
  logic [NUM_WIDTH+3:0]   acc_mul;
  logic [NUM_WIDTH-1:0]   acc_next;
  logic [CmpWidth-1:0]    acc_ext;
  logic [CmpWidth-1:0]    limit_ext;
  logic                   num_ok;
  logic [BulkWidth-1:0]   bulk_dec;
  logic [ArgsWidth:0]     seen_inc;
  logic                   last_arg;
  logic                   last_cmd;
  logic                   err_hit;
  err_code_e              err_code;

  assign is_cr      = (byte_i == CharCr);
  assign is_lf      = (byte_i == CharLf);
  assign is_digit   = (byte_i >= CharZero) && (byte_i <= CharNine);
  assign digit_full = byte_i - CharZero;

  // acc * 10 + digit as shift-add, saturating at all ones
  assign acc_wide = {4'b0000, acc_i};
  assign acc_mul  = (acc_wide << 3) + (acc_wide << 1) + {{NUM_WIDTH{1'b0}}, digit_full[3:0]};
  assign acc_next = (acc_mul[NUM_WIDTH+3:NUM_WIDTH] != 4'd0) ? SatValue
                                                             : acc_mul[NUM_WIDTH-1:0];

  assign acc_ext   = CmpWidth'(acc_i);
  assign limit_ext = (state_i.phase == PH_ARR_NUM) ? CmpWidth'(max_args_i)
                                                   : CmpWidth'(max_bulk_len_i);
  assign num_ok    = (acc_i != '0) && (acc_i != SatValue) && (acc_ext <= limit_ext);

  assign bulk_dec = state_i.bulk_remaining - BulkWidth'(1);
  assign seen_inc = {1'b0, state_i.args_seen} + (ArgsWidth+1)'(1);
  assign last_arg = (bulk_dec == '0);
  assign last_cmd = last_arg && (seen_inc >= {1'b0, state_i.args_expected});

  always_comb begin
    state_o  = state_i;
    acc_o    = acc_i;
    emit_o   = 1'b0;
    result_o = '0;
    err_hit  = 1'b0;
    err_code = ERR_NONE;

    case (state_i.phase)
      PH_IDLE: begin
        if (is_cr || is_lf) begin
          // skip loose line breaks between segments
        end else if (byte_i == CharStar) begin
          if (state_i.args_expected != '0) begin
            err_hit  = 1'b1;
            err_code = ERR_NESTED;
          end else begin
            acc_o         = '0;
            state_o.phase = PH_ARR_NUM;
          end
        end else if (byte_i == CharDollar) begin
          if (state_i.args_expected == '0) begin
            err_hit  = 1'b1;
            err_code = ERR_NO_ARRAY;
          end else begin
            acc_o         = '0;
            state_o.phase = PH_LEN_NUM;
          end
        end else begin
          err_hit  = 1'b1;
          err_code = ERR_UNEXPECTED;
        end
      end

      PH_ARR_NUM, PH_LEN_NUM: begin
        if (is_cr) begin
          if (!num_ok) begin
            err_hit  = 1'b1;
            err_code = ERR_BAD_NUMBER;
          end else begin
            state_o.phase = (state_i.phase == PH_ARR_NUM) ? PH_ARR_LF : PH_LEN_LF;
          end
        end else if (is_digit) begin
          acc_o = acc_next;
        end else begin
          err_hit  = 1'b1;
          err_code = ERR_BAD_NUMBER;
        end
      end

      PH_ARR_LF: begin
        if (!is_lf) begin
          err_hit  = 1'b1;
          err_code = ERR_UNEXPECTED;
        end else begin
          state_o.args_expected = acc_ext[ArgsWidth-1:0];
          state_o.args_seen     = '0;
          state_o.phase         = PH_IDLE;
        end
      end

      PH_LEN_LF: begin
        if (!is_lf) begin
          err_hit  = 1'b1;
          err_code = ERR_UNEXPECTED;
        end else begin
          state_o.bulk_remaining = acc_ext[BulkWidth-1:0];
          state_o.phase          = PH_DATA1;
        end
      end

      PH_DATA1, PH_DATA: begin
        emit_o                   = 1'b1;
        result_o.data_byte       = byte_i;
        result_o.arg_index       = state_i.args_seen;
        result_o.first_of_arg    = (state_i.phase == PH_DATA1);
        result_o.last_of_arg     = last_arg;
        result_o.last_of_command = last_cmd;
        state_o.bulk_remaining   = bulk_dec;
        if (last_arg) begin
          state_o.phase = PH_IDLE;
          if (last_cmd) begin
            state_o.args_expected = '0;
            state_o.args_seen     = '0;
          end else begin
            state_o.args_seen = seen_inc[ArgsWidth-1:0];
          end
        end else begin
          state_o.phase = PH_DATA;
        end
      end

      PH_ERR: begin
        // stopped: drop every byte
      end

      default: begin
      end
    endcase

    if (err_hit) begin
      state_o.phase       = PH_ERR;
      emit_o              = 1'b1;
      result_o            = '0;
      result_o.is_error   = 1'b1;
      result_o.error_code = err_code;
    end
  end

endmodule

@@ sv/resp_request_parser_core.sv @@
// ----------------------------------------------------------------------------
// resp_request_parser_core: multi-bulk RESP request parser, one byte per cycle
// Splits a request byte stream into tagged argument bytes and reports errors.
// ----------------------------------------------------------------------------
// Feed the request stream one byte per transfer on the in_* channel. Each
// command is '*count' CR LF followed by count bulk arguments '$len' CR LF and
// len payload bytes; CR/LF bytes between segments are skipped. Every payload
// byte comes out as one transfer on the out_* channel with its argument index
// and first-of-argument, last-of-argument and last-of-command flags. Header
// bytes produce no output. A parse error (nested array, length without array,
// unexpected byte, bad number) produces one error transfer and the parser then
// drops all input until reset. Throughput is one byte per cycle: the byte
// register feeds the parse logic and the result register in a single pass,
// and both advance together whenever the result register is empty or being
// drained. A byte goes through the byte register and then the result register.
// The limit registers max_args (index 0) and max_bulk_len (index 1) are
// written through cfg_*; write them only while no bytes are in flight.
module resp_request_parser_core import rrp_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NumWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CfgWidth-1:0]   cfg_wdata_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            data_byte_o,
  output logic [ArgsWidth-1:0]  arg_index_o,
  output logic                  first_of_arg_o,
  output logic                  last_of_arg_o,
  output logic                  last_of_command_o,
  output logic                  is_error_o,
  output logic [2:0]            error_code_o
);

  // limit registers
  logic [ArgsWidth-1:0]  max_args_q;
  logic [BulkWidth-1:0]  max_bulk_len_q;

  // input byte register
  logic                  byte_valid_q;
  logic [7:0]            byte_q;

  // parser state
  parse_state_t          state_q, state_d;
  logic [NUM_WIDTH-1:0]  acc_q, acc_d;

  // result register
  logic                  res_valid_q;
  result_t               res_q;
  result_t               res_d;
  logic                  emit;

  logic                  advance;

  // Process the held byte when the result slot is free or drains this cycle.
  assign advance    = byte_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !byte_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q     <= MaxArgsReset;
      max_bulk_len_q <= MaxBulkLenReset;
    end else if (cfg_we_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_MAX_ARGS:     max_args_q     <= cfg_wdata_i[ArgsWidth-1:0];
        REG_MAX_BULK_LEN: max_bulk_len_q <= cfg_wdata_i[BulkWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  // Capture the payload on every transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  rrp_step #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_step (
    .state_i        (state_q),
    .acc_i          (acc_q),
    .byte_i         (byte_q),
    .max_args_i     (max_args_q),
    .max_bulk_len_i (max_bulk_len_q),
    .state_o        (state_d),
    .acc_o          (acc_d),
    .emit_o         (emit),
    .result_o       (res_d)
  );

  // Advance the parser state once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
      acc_q   <= '0;
    end else if (advance) begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // Result slot: load on an emitting byte, clear once drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= emit;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign data_byte_o       = res_q.data_byte;
  assign arg_index_o       = res_q.arg_index;
  assign first_of_arg_o    = res_q.first_of_arg;
  assign last_of_arg_o     = res_q.last_of_arg;
  assign last_of_command_o = res_q.last_of_command;
  assign is_error_o        = res_q.is_error;
  assign error_code_o      = res_q.error_code;

endmodule

@@ bench/tb_resp_request_parser_core.sv @@
// ----------------------------------------------------------------------------
// tb_resp_request_parser_core: self-checking bench of the RESP request parser
// Feeds well-formed multi-bulk commands with random payloads, loose CR/LF and
// leading zeros under several limit settings, predicts every tagged payload
// byte, and ends each run on one randomly chosen parse error and the noise
// after it, which must produce nothing.
// ----------------------------------------------------------------------------
module tb_resp_request_parser_core import rrp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumW = NumWidthDefault;
  // Bytes of random commands per limit setting.
  localparam int PhaseBytes = 215;
  // Cycles without any transfer before the run is declared hung.
  localparam int QuietLimit = 2000;

  // Error tails: the parser latches its first error, so each run ends on one.
  typedef enum int {
    TAIL_NESTED,
    TAIL_NO_ARRAY,
    TAIL_STRAY_BYTE,
    TAIL_MISSING_LF,
    TAIL_NON_DIGIT,
    TAIL_ZERO_LENGTH,
    TAIL_EMPTY_COUNT,
    TAIL_OVER_LIMIT,
    TAIL_SATURATED,
    TAIL_ZERO_LIMIT
  } tail_kind_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_index_i = REG_MAX_ARGS;
  logic [CfgWidth-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           in_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b1;
  logic [7:0]           data_byte_o;
  logic [ArgsWidth-1:0] arg_index_o;
  logic                 first_of_arg_o;
  logic                 last_of_arg_o;
  logic                 last_of_command_o;
  logic                 is_error_o;
  logic [2:0]           error_code_o;

  resp_request_parser_core #(
    .NUM_WIDTH (NumW)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .data_byte_o       (data_byte_o),
    .arg_index_o       (arg_index_o),
    .first_of_arg_o    (first_of_arg_o),
    .last_of_arg_o     (last_of_arg_o),
    .last_of_command_o (last_of_command_o),
    .is_error_o        (is_error_o),
    .error_code_o      (error_code_o)
  );

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the parse state byte by byte and keeps the tagged
  // bytes and error reports that the block owes, oldest first.
  // --------------------------------------------------------------------------
  class request_scoreboard;
    logic [ArgsWidth-1:0] args_limit;
    logic [BulkWidth-1:0] bulk_limit;
    phase_e               phase;
    logic [NumW-1:0]      acc;
    logic [ArgsWidth-1:0] args_expected;
    logic [ArgsWidth-1:0] args_seen;
    logic [BulkWidth-1:0] bulk_left;
    result_t              due_q[$];
    int                   mismatches;
    int                   checked;

    function new();
      args_limit    = MaxArgsReset;
      bulk_limit    = MaxBulkLenReset;
      phase         = PH_IDLE;
      acc           = '0;
      args_expected = '0;
      args_seen     = '0;
      bulk_left     = '0;
      mismatches    = 0;
      checked       = 0;
    endfunction

    function void set_limit(reg_index_e idx, logic [CfgWidth-1:0] value);
      if (idx == REG_MAX_ARGS) args_limit = value[ArgsWidth-1:0];
      else bulk_limit = value[BulkWidth-1:0];
    endfunction

    // Latch the error and owe one error report.
    function void raise_error(err_code_e code);
      result_t r;
      r = '0;
      r.is_error = 1'b1;
      r.error_code = code;
      phase = PH_ERR;
      due_q = {due_q, r};
    endfunction

    // Zero, the saturated value and anything above the limit are bad numbers.
    function bit number_fits(longint unsigned limit);
      longint unsigned value;
      value = 64'(acc);
      return acc != '0 && acc != '1 && value <= limit;
    endfunction

    function void add_digit(logic [7:0] b);
      longint unsigned value;
      longint unsigned ceiling;
      ceiling = (64'd1 << NumW) - 1;
      value = longint'(acc) * 10 + (b - CharZero);
      if (value > ceiling) value = ceiling;
      acc = value[NumW-1:0];
    endfunction

    // Advance the parse state by one accepted byte.
    function void note_byte(logic [7:0] b);
      result_t r;
      bit      last_arg;
      r = '0;
      case (phase)
        PH_IDLE: begin
          if (b == CharCr || b == CharLf) begin
            // skip loose line ends between segments
          end else if (b == CharStar) begin
            if (args_expected != 0) raise_error(ERR_NESTED);
            else begin
              acc = '0;
              phase = PH_ARR_NUM;
            end
          end else if (b == CharDollar) begin
            if (args_expected == 0) raise_error(ERR_NO_ARRAY);
            else begin
              acc = '0;
              phase = PH_LEN_NUM;
            end
          end else begin
            raise_error(ERR_UNEXPECTED);
          end
        end
        PH_ARR_NUM, PH_LEN_NUM: begin
          if (b == CharCr) begin
            if (phase == PH_ARR_NUM) begin
              if (!number_fits(64'(args_limit))) raise_error(ERR_BAD_NUMBER);
              else phase = PH_ARR_LF;
            end else begin
              if (!number_fits(64'(bulk_limit))) raise_error(ERR_BAD_NUMBER);
              else phase = PH_LEN_LF;
            end
          end else if (b < CharZero || b > CharNine) begin
            raise_error(ERR_BAD_NUMBER);
          end else begin
            add_digit(b);
          end
        end
        PH_ARR_LF: begin
          if (b != CharLf) raise_error(ERR_UNEXPECTED);
          else begin
            args_expected = acc[ArgsWidth-1:0];
            args_seen = '0;
            phase = PH_IDLE;
          end
        end
        PH_LEN_LF: begin
          if (b != CharLf) raise_error(ERR_UNEXPECTED);
          else begin
            bulk_left = acc[BulkWidth-1:0];
            phase = PH_DATA1;
          end
        end
        PH_DATA1, PH_DATA: begin
          bulk_left = bulk_left - 1'b1;
          last_arg = (bulk_left == 0);
          r.data_byte = b;
          r.arg_index = args_seen;
          r.first_of_arg = (phase == PH_DATA1);
          r.last_of_arg = last_arg;
          r.last_of_command = last_arg && (int'(args_seen) + 1 >= int'(args_expected));
          r.error_code = ERR_NONE;
          due_q = {due_q, r};
          if (last_arg) begin
            phase = PH_IDLE;
            if (r.last_of_command) begin
              args_expected = '0;
              args_seen = '0;
            end else begin
              args_seen = args_seen + 1'b1;
            end
          end else begin
            phase = PH_DATA;
          end
        end
        default: begin
          // error latched: drop the byte
        end
      endcase
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        $display("%0t: result with nothing owed, expected none, actual %h",
                 $realtime, got);
        mismatches++;
        return;
      end
      want = due_q.pop_front();
      checked++;
      compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      compare_field("arg_index", want.arg_index, got.arg_index);
      compare_field("first_of_arg", 16'(want.first_of_arg), 16'(got.first_of_arg));
      compare_field("last_of_arg", 16'(want.last_of_arg), 16'(got.last_of_arg));
      compare_field("last_of_command", 16'(want.last_of_command),
                    16'(got.last_of_command));
      compare_field("is_error", 16'(want.is_error), 16'(got.is_error));
      compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
    endfunction
  endclass

  request_scoreboard sb;

  int                   bytes_sent = 0;
  int                   commands_sent = 0;
  int                   src_odds = 0;
  int                   sink_odds = 0;
  int                   stall_left = 0;
  int                   quiet = 0;
  logic [ArgsWidth-1:0] args_cap = MaxArgsReset;
  logic [BulkWidth-1:0] bulk_cap = MaxBulkLenReset;
  tail_kind_e           tail;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Monitor both channels at the edge: feed accepted bytes to the tracker
  // and check every result transfer against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_byte_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result({data_byte_o, arg_index_o, first_of_arg_o, last_of_arg_o,
                         last_of_command_o, is_error_o, error_code_o});
      end
    end
  end

  // Result side: hold out_ready low in random bursts while sink_odds is nonzero.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready_i <= 1'b1;
    end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(1, 16);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results still owed",
                 $realtime, QuietLimit, sb.due_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until the transfer; maybe idle first.
  task automatic send_byte(logic [7:0] b);
    if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send lead byte, decimal digits, CR, LF.
  task automatic send_header(logic [7:0] lead, string digits);
    int i;
    send_byte(lead);
    for (i = 0; i < digits.len(); i++) send_byte(digits[i]);
    send_byte(CharCr);
    send_byte(CharLf);
  endtask

  // Sometimes pad with one or two leading zeros, which must be accepted.
  function automatic string decimal(longint unsigned value);
    string s;
    s = $sformatf("%0d", value);
    if ($urandom_range(0, 5) == 0) s = {"0", s};
    if ($urandom_range(0, 11) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic logic [7:0] non_digit_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CharZero && b <= CharNine) || b == CharCr);
    return b;
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CharStar || b == CharDollar || b == CharCr || b == CharLf);
    return b;
  endfunction

  // Loose CR/LF bytes that the parser skips between segments.
  task automatic send_loose();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) send_byte($urandom_range(0, 1) ? CharCr : CharLf);
    end
  endtask

  // One well-formed command with random argument count, lengths and payload,
  // staying within the current limits and hitting small ones now and then.
  task automatic send_command();
    int cap_args;
    int cap_len;
    int nargs;
    int len;
    int a;
    cap_args = (args_cap < 6) ? int'(args_cap) : 6;
    cap_len = (bulk_cap < 8) ? int'(bulk_cap) : 8;
    nargs = ($urandom_range(0, 7) == 0) ? cap_args : $urandom_range(1, cap_args);
    send_loose();
    send_header(CharStar, decimal(64'(nargs)));
    for (a = 0; a < nargs; a++) begin
      send_loose();
      len = $urandom_range(1, cap_len);
      if ($urandom_range(0, 9) == 0) len = (bulk_cap < 40) ? int'(bulk_cap) : 40;
      send_header(CharDollar, decimal(64'(len)));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      // The line end after a payload is optional; usually send it.
      if ($urandom_range(0, 2) != 0) begin
        send_byte(CharCr);
        send_byte(CharLf);
      end
    end
    commands_sent++;
  endtask

  task automatic fill_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) send_command();
  endtask

  // Drop valid, wait for every owed result, then let the pipe settle.
  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_limits(logic [CfgWidth-1:0] args_word, logic [CfgWidth-1:0] bulk_word);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_MAX_ARGS;
    cfg_wdata_i <= args_word;
    @(posedge clk_i);
    sb.set_limit(REG_MAX_ARGS, args_word);
    cfg_index_i <= REG_MAX_BULK_LEN;
    cfg_wdata_i <= bulk_word;
    @(posedge clk_i);
    sb.set_limit(REG_MAX_BULK_LEN, bulk_word);
    cfg_we_i <= 1'b0;
    args_cap = args_word[ArgsWidth-1:0];
    bulk_cap = bulk_word[BulkWidth-1:0];
  endtask

  task automatic set_idling(int src, int sink);
    src_odds = src;
    sink_odds <= sink;
  endtask

  // Force one parse error; the parser is idle with no array pending here.
  task automatic send_error_tail();
    tail = tail_kind_e'($urandom_range(0, 9));
    case (tail)
      TAIL_NESTED: begin
        send_header(CharStar, "2");
        send_byte(CharStar);
      end
      TAIL_NO_ARRAY:   send_byte(CharDollar);
      TAIL_STRAY_BYTE: send_byte(stray_byte());
      TAIL_MISSING_LF: begin
        send_byte(CharStar);
        send_byte("1");
        send_byte(CharCr);
        send_byte($urandom_range(0, 1) ? CharCr : CharStar);
      end
      TAIL_NON_DIGIT: begin
        send_header(CharStar, "1");
        send_byte(CharDollar);
        send_byte("3");
        send_byte(non_digit_byte());
      end
      TAIL_ZERO_LENGTH: begin
        send_header(CharStar, "1");
        send_byte(CharDollar);
        send_byte(CharZero);
        send_byte(CharZero);
        send_byte(CharCr);
      end
      TAIL_EMPTY_COUNT: begin
        send_byte(CharStar);
        send_byte(CharCr);
      end
      TAIL_OVER_LIMIT: begin
        if ($urandom_range(0, 1)) begin
          send_header(CharStar, decimal(longint'(args_cap) + 1));
        end else begin
          send_header(CharStar, "1");
          send_header(CharDollar, decimal(longint'(bulk_cap) + 1));
        end
      end
      TAIL_SATURATED: send_header(CharStar, "99999999999");
      default: begin
        // a zero limit turns every count into a bad number
        drain(4);
        write_limits('0, bulk_cap);
        send_header(CharStar, "1");
      end
    endcase
    // Everything after the error must be swallowed without a result.
    send_header(CharStar, "1");
    send_header(CharDollar, "4");
    repeat (12) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: limits at reset, extremes of the payload byte, loose line
    // ends, leading zero, no line end after a payload, header chars as data.
    set_idling(5, 6);
    send_header(CharStar, "1");
    send_header(CharDollar, "1");
    send_byte(8'hFF);
    send_byte(CharCr);
    send_byte(CharLf);
    send_header(CharStar, "02");
    send_header(CharDollar, "1");
    send_byte(8'h00);
    send_byte(CharLf);
    send_header(CharDollar, "2");
    send_byte(CharStar);
    send_byte(CharDollar);
    fill_phase();

    // Smallest limits: every command is one one-byte argument.
    drain(4);
    set_idling(3, 3);
    write_limits(CfgWidth'(1), CfgWidth'(1));
    fill_phase();

    // Largest max_args and the reset max_bulk_len.
    drain(4);
    set_idling(8, 0);
    write_limits(CfgWidth'(16'd65535), 30'd536870912);
    fill_phase();

    // Small limits reached exactly; upper word bits of max_args are junk.
    drain(4);
    set_idling(0, 4);
    write_limits({14'h2A5, 16'd3}, CfgWidth'(7));
    fill_phase();

    drain(4);
    set_idling(6, 10);
    write_limits(CfgWidth'($urandom_range(1, 8)), CfgWidth'($urandom_range(1, 24)));
    fill_phase();

    // Last stretch runs at full rate on both sides.
    drain(4);
    set_idling(0, 0);
    write_limits(CfgWidth'($urandom_range(2, 6)), 30'h3FFF_FFFF);
    fill_phase();
    send_error_tail();

    drain(8);
    $display("Sent %0d bytes in %0d commands over six limit settings, checked %0d results",
             bytes_sent, commands_sent, sb.checked);
    $display("Run closed on error tail %s", tail.name());
    if (sb.due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, sb.due_q.size());
    end
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
